/* sv/shader_output_slot_mapper_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shader output slot mapper
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHADER_OUTPUT_SLOT_MAPPER_DEFINES_SVH
`define SHADER_OUTPUT_SLOT_MAPPER_DEFINES_SVH

// same-cycle implication
`define SOSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slot mapper check failed");

// next-cycle implication
`define SOSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slot mapper check failed");

`endif

/* sv/sosm_pkg.sv */
// ----------------------------------------------------------------------------
// sosm_pkg
// Types and constants shared by the slot mapper controller and datapath.
// ----------------------------------------------------------------------------
package sosm_pkg;

  localparam int unsigned F24_W       = 24;
  localparam int unsigned ATTR_IDX_W  = 3;
  localparam int unsigned NUM_COMPS   = 4;
  localparam int unsigned COMP_W      = 2;
  localparam int unsigned MAP_BYTE_W  = 8;
  localparam int unsigned MAP_W       = 32;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned SLOT_IDX_W  = 5;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [F24_W-1:0] F24_ONE      = 24'h3F0000;
  localparam logic [F24_W-1:0] F24_MAG_MASK = 24'h7FFFFF;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_COUNT = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ATTR_MAP_0   = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic item_load;  // capture accepted beat
    logic wr_step;    // write current component, advance
    logic rd_issue;   // read next slot for emission
    logic clear;      // drop all slot valid bits
  } cmd_t;

  typedef struct packed {
    logic comp_last;  // current component is w
    logic item_last;  // captured beat closes the vertex
    logic rd_free;    // read stage can take a slot this cycle
    logic rd_addr_last;
  } status_t;

endpackage

/* sv/sosm_ctrl.sv */
// ----------------------------------------------------------------------------
// sosm_ctrl
// Sequencer: accept, write four components, then after a tlast beat stream the slots out.
// ----------------------------------------------------------------------------
module sosm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  sosm_pkg::status_t status_i,
  output sosm_pkg::cmd_t    cmd_o
);
  import sosm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.comp_last) state_d = status_i.item_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status_i.rd_free && status_i.rd_addr_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o      = 1'b1;
        cmd_o.item_load = s_valid_i;
      end
      ST_WRITE: begin
        cmd_o.wr_step = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.rd_issue = status_i.rd_free;
        cmd_o.clear    = status_i.rd_free && status_i.rd_addr_last;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* sv/sosm_datapath.sv */
// ----------------------------------------------------------------------------
// sosm_datapath
// Config registers, slot store, read stage and output register.
// ----------------------------------------------------------------------------
module sosm_datapath #(
  parameter int unsigned SLOT_COUNT = 24,
  parameter int unsigned NUM_ATTRS  = 7,
  parameter int unsigned COLOR_SLOT = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [sosm_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [sosm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [sosm_pkg::IN_TDATA_W-1:0]       s_tdata_i,
  input  logic                                  s_tlast_i,
  input  logic                                  m_tready_i,
  output logic                                  m_tvalid_o,
  output logic [sosm_pkg::OUT_TDATA_W-1:0]      m_tdata_o,
  output logic                                  m_tlast_o,
  input  sosm_pkg::cmd_t                        cmd_i,
  output sosm_pkg::status_t                     status_o
);
  import sosm_pkg::*;

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // config
  logic [COUNT_W-1:0] count_q;
  logic [MAP_W-1:0]   map_q [NUM_ATTRS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int a = 0; a < NUM_ATTRS; a++) map_q[a] <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == REG_OUTPUT_COUNT) count_q <= cfg_data_i[COUNT_W-1:0];
      for (int a = 0; a < NUM_ATTRS; a++) begin
        if (cfg_addr_i == CFG_ADDR_W'(int'(REG_ATTR_MAP_0) + a)) map_q[a] <= cfg_data_i;
      end
    end
  end

  // captured item
  logic [ATTR_IDX_W-1:0] idx_q;
  logic [F24_W-1:0]      comp_q [NUM_COMPS];
  logic                  last_q;
  logic [COMP_W-1:0]     comp_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      idx_q  <= s_tdata_i[ATTR_IDX_W-1:0];
      last_q <= s_tlast_i;
      for (int c = 0; c < NUM_COMPS; c++) begin
        comp_q[c] <= s_tdata_i[ATTR_IDX_W + c*F24_W +: F24_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_cnt_q <= '0;
    end else if (cmd_i.item_load) begin
      comp_cnt_q <= '0;
    end else if (cmd_i.wr_step) begin
      comp_cnt_q <= comp_cnt_q + COMP_W'(1);
    end
  end

  // slot target for the current component
  logic [MAP_W-1:0]      map_sel;
  logic [MAP_BYTE_W-1:0] map_byte;
  logic                  attr_used;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;

  always_comb begin
    map_sel = '1;
    for (int a = 0; a < NUM_ATTRS; a++) begin
      if (idx_q == ATTR_IDX_W'(a)) map_sel = map_q[a];
    end
  end

  assign map_byte  = MAP_BYTE_W'(map_sel >> {comp_cnt_q, 3'b000});
  assign attr_used = (idx_q < count_q) && (idx_q < ATTR_IDX_W'(NUM_ATTRS));
  assign wr_en     = cmd_i.wr_step && attr_used && (map_byte < MAP_BYTE_W'(SLOT_COUNT));
  assign wr_addr   = map_byte[SLOT_W-1:0];

  // slot store; an entry without its valid bit reads as one
  logic [F24_W-1:0]      mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_q;
  logic [SLOT_W-1:0]     rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= comp_q[comp_cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (cmd_i.clear) begin
      slot_vld_q <= '0;
    end else if (wr_en) begin
      slot_vld_q[wr_addr] <= 1'b1;
    end
  end

  logic rd_addr_last;
  assign rd_addr_last = (rd_addr_q == SLOT_W'(SLOT_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
    end else if (cmd_i.rd_issue) begin
      rd_addr_q <= rd_addr_last ? '0 : rd_addr_q + SLOT_W'(1);
    end
  end

  // read stage
  logic              rd_vld_q;
  logic [F24_W-1:0]  rd_raw_q;
  logic              rd_hit_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_last_q;
  logic              m_vld_q;
  logic              load_out;

  assign load_out = rd_vld_q && (!m_vld_q || m_tready_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_raw_q  <= mem_q[rd_addr_q];
      rd_hit_q  <= slot_vld_q[rd_addr_q];
      rd_idx_q  <= rd_addr_q;
      rd_last_q <= rd_addr_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (cmd_i.rd_issue) begin
      rd_vld_q <= 1'b1;
    end else if (load_out) begin
      rd_vld_q <= 1'b0;
    end
  end

  // colour saturation on the way out
  logic [F24_W-1:0] rd_val;
  logic [F24_W-1:0] rd_mag;
  logic             rd_color;
  logic [F24_W-1:0] out_val;

  assign rd_val   = rd_hit_q ? rd_raw_q : F24_ONE;
  assign rd_mag   = rd_val & F24_MAG_MASK;
  assign rd_color = (int'(rd_idx_q) >= COLOR_SLOT) && (int'(rd_idx_q) < COLOR_SLOT + 4);
  assign out_val  = rd_color ? ((rd_mag < F24_ONE) ? rd_mag : F24_ONE) : rd_val;

  // output register
  logic [F24_W-1:0]      m_val_q;
  logic [SLOT_IDX_W-1:0] m_idx_q;
  logic                  m_last_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_val_q  <= out_val;
      m_idx_q  <= SLOT_IDX_W'(rd_idx_q);
      m_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (load_out) begin
      m_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      m_vld_q <= 1'b0;
    end
  end

  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = {(OUT_TDATA_W - F24_W - SLOT_IDX_W)'(0), m_val_q, m_idx_q};
  assign m_tlast_o  = m_last_q;

  assign status_o.comp_last    = (comp_cnt_q == COMP_W'(NUM_COMPS - 1));
  assign status_o.item_last    = last_q;
  assign status_o.rd_free      = !rd_vld_q || load_out;
  assign status_o.rd_addr_last = rd_addr_last;

endmodule

/* sv/shader_output_slot_mapper.sv */
// ----------------------------------------------------------------------------
// shader_output_slot_mapper
// Gathers shader output attributes into semantic slots and emits one vertex.
// ----------------------------------------------------------------------------
// Each input beat carries one attribute; its four f24 components are written,
// one per cycle through the single write port of the slot store, to the slots
// named by the attribute's map register, so once accepted a beat holds the
// input closed through its four component writes. A beat flagged tlast then
// streams all SLOT_COUNT slots out in slot order, one beat per cycle from the
// store's single read port when the sink keeps up, with the input closed
// until the top slot is read. Colour slots COLOR_SLOT..COLOR_SLOT+3 leave
// as magnitudes clamped to 1.0; unwritten slots read as 1.0 and the store
// falls back to 1.0 after each vertex. Configuration writes are always taken.
`include "shader_output_slot_mapper_defines.svh"

module shader_output_slot_mapper #(
  parameter int unsigned SLOT_COUNT = 24,  // 8..32
  parameter int unsigned NUM_ATTRS  = 7,   // 1..7
  parameter int unsigned COLOR_SLOT = 8    // 0..20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sosm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [sosm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // attribute stream in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // attr_index[2:0], comp_x[26:3], comp_y[50:27], comp_z[74:51], comp_w[98:75]
  input  logic [sosm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                               s_axis_tlast,   // last_attr
  // slot stream out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // slot_index[4:0], slot_value[28:5]
  output logic [sosm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast    // last_slot
);
  import sosm_pkg::*;

  cmd_t    cmd;
  status_t status;

  // output beat fields, for the checks
  logic [SLOT_IDX_W-1:0] out_slot;
  logic [F24_W-1:0]      out_value;
  logic                  out_colour;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  sosm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  sosm_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .NUM_ATTRS  (NUM_ATTRS),
    .COLOR_SLOT (COLOR_SLOT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // ---- checks ----
  assign out_slot   = m_axis_tdata[SLOT_IDX_W-1:0];
  assign out_value  = m_axis_tdata[SLOT_IDX_W +: F24_W];
  assign out_colour = (int'(out_slot) >= COLOR_SLOT) && (int'(out_slot) < COLOR_SLOT + 4);

  // the closing beat of a vertex always names the top slot
  `SOSM_ASSERT_NOW(a_last_is_top_slot, m_axis_tvalid && m_axis_tlast, out_slot == SLOT_IDX_W'(SLOT_COUNT - 1))
  // colour slots never leave above one, and never negative
  `SOSM_ASSERT_NOW(a_color_clamped, m_axis_tvalid && out_colour, out_value <= F24_ONE)
  // an accepted beat keeps the input closed while its components are written
  `SOSM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
